[src/rotary_encoder_position_tracker_top_assert.svh]
// Assertion macros shared by the rotary encoder position tracker RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ROTARY_ENCODER_POSITION_TRACKER_TOP_ASSERT_SVH
`define ROTARY_ENCODER_POSITION_TRACKER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted
`define REPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rept assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define REPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rept assertion failed");

`else

`define REPT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define REPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/rept_pkg.sv]
// Shared types and codes for the rotary encoder position tracker.
// No dependencies; used by rept_core and the top level.
`timescale 1ns / 1ps

package rept_pkg;

    // Field widths
    localparam int POS_W  = 8;
    localparam int TIME_W = 16;
    localparam int DB_W   = 8;
    localparam int IDX_W  = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_MIN_POS   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_POS   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_WRAP      = 3'd3;
    localparam logic [IDX_W-1:0] CFG_START_POS = 3'd4;

    // Request command codes
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_SET_POS = 1'b1;

    // Configuration register file contents
    typedef struct packed {
        logic [DB_W-1:0]  debounce_ms;
        logic [POS_W-1:0] min_position;
        logic [POS_W-1:0] max_position;
        logic             wrap_enable;
    } t_cfg;

    // One input request
    typedef struct packed {
        logic              cmd;
        logic              pin_a;
        logic              pin_b;
        logic [TIME_W-1:0] now_ms;
        logic [POS_W-1:0]  new_position;
    } t_item;

    // One result
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             changed;
    } t_result;

endpackage

[src/rotary_encoder_position_tracker_top.sv]
// Rotary encoder position tracker top level: config registers, input
// handshake and output register around rept_core. Uses rept_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request per accept:
//   a pin sample (cmd 0: pin A, pin B, ms timestamp) or a set-position
//   request (cmd 1: new position, loaded only if within min..max).
//   Output channel (o_out_valid / i_out_stall) returns exactly one result
//   per request: the position after it and the changed flag.
//   Output valid rises in the cycle after input accept. Throughput is one
//   request per cycle unless stalled; the update is a single combinational
//   pass from the presented request and the state registers into the
//   result register, and the state registers update at the same edge.
//   While the receiver stalls a held result, o_in_stall rises and the
//   result holds; a result being taken frees the register for the next one
//   in the same cycle.
//   Config writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at the
//   clock edge; writing the start position also loads the position.
//   Synchronous reset restores register defaults (max 255, others 0),
//   position 0, idle-high A, and empties the output register.
`timescale 1ns / 1ps
`include "rotary_encoder_position_tracker_top_assert.svh"

module rotary_encoder_position_tracker_top
    import rept_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [POS_W-1:0]  i_cfg_data,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cmd,
    input  logic              i_pin_a,
    input  logic              i_pin_b,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic [POS_W-1:0]  i_new_position,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_position,
    output logic              o_changed
);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_result;

    t_item   item;
    t_result result;
    logic    in_accept;
    logic    start_we;

    // Request accepted when the output register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign start_we   = i_cfg_we && (i_cfg_index == CFG_START_POS);

    assign item.cmd          = i_cmd;
    assign item.pin_a        = i_pin_a;
    assign item.pin_b        = i_pin_b;
    assign item.now_ms       = i_now_ms;
    assign item.new_position = i_new_position;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms  <= '0;
            r_cfg.min_position <= '0;
            r_cfg.max_position <= '1;
            r_cfg.wrap_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_cfg.debounce_ms  <= i_cfg_data[DB_W-1:0];
                CFG_MIN_POS:  r_cfg.min_position <= i_cfg_data;
                CFG_MAX_POS:  r_cfg.max_position <= i_cfg_data;
                CFG_WRAP:     r_cfg.wrap_enable  <= i_cfg_data[0];
                default:      r_cfg.wrap_enable  <= r_cfg.wrap_enable;
            endcase
        end
    end

    rept_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start_we  (start_we),
        .i_start_pos (i_cfg_data),
        .i_accept    (in_accept),
        .i_item      (item),
        .o_result    (result)
    );

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, loaded with each accepted request
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_result.position;
    assign o_changed   = r_result.changed;

    // Every accepted request leaves a result in the output register
    `REPT_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n,
        in_accept, r_out_valid && (r_result == $past(result)))
    // No request is taken while a held result is stalled
    `REPT_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n,
        r_out_valid && i_out_stall, !in_accept)

endmodule

[src/rept_core.sv]
// Tracker state and single-pass next-state logic: edge detect, debounce,
// position step with limits, set-position and change reporting. Uses rept_pkg.
`timescale 1ns / 1ps
`include "rotary_encoder_position_tracker_top_assert.svh"

module rept_core
    import rept_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_start_we,
    input  logic [POS_W-1:0] i_start_pos,
    input  logic             i_accept,
    input  t_item            i_item,
    output t_result          o_result
);

    logic [POS_W-1:0]  r_position;
    logic              r_prev_a;
    logic [TIME_W-1:0] r_last_edge;
    logic [POS_W-1:0]  r_reported;
    logic              r_changed;

    logic [POS_W-1:0]  n_position;
    logic              n_prev_a;
    logic [TIME_W-1:0] n_last_edge;
    logic [POS_W-1:0]  n_reported;
    logic              n_changed;

    logic [TIME_W-1:0] delta;
    logic              edge_ok;
    logic [POS_W-1:0]  stepped;
    logic              in_range;

    // Debounced falling edge of A
    always_comb begin
        delta   = i_item.now_ms - r_last_edge;
        edge_ok = r_prev_a && !i_item.pin_a &&
                  (delta > {{(TIME_W-DB_W){1'b0}}, i_cfg.debounce_ms});
    end

    // Position after one step; B high steps up, B low steps down
    always_comb begin
        stepped = r_position;
        if (i_item.pin_b) begin
            if (r_position < i_cfg.max_position) begin
                stepped = r_position + POS_W'(1);
            end else if (i_cfg.wrap_enable) begin
                stepped = i_cfg.min_position;
            end
        end else begin
            if (r_position > i_cfg.min_position) begin
                stepped = r_position - POS_W'(1);
            end else if (i_cfg.wrap_enable) begin
                stepped = i_cfg.max_position;
            end
        end
    end

    // Next state for the request presented this cycle
    always_comb begin
        in_range    = (i_item.new_position >= i_cfg.min_position) &&
                      (i_item.new_position <= i_cfg.max_position);
        n_position  = r_position;
        n_prev_a    = r_prev_a;
        n_last_edge = r_last_edge;
        n_reported  = r_reported;
        n_changed   = r_changed;
        case (i_item.cmd)
            CMD_SET_POS: begin
                if (in_range) begin
                    n_position = i_item.new_position;
                end
            end
            CMD_SAMPLE: begin
                if (edge_ok) begin
                    n_position  = stepped;
                    n_last_edge = i_item.now_ms;
                end
                n_prev_a   = i_item.pin_a;
                n_changed  = (n_position != r_reported);
                n_reported = n_position;
            end
            default: begin
                n_position = r_position;
            end
        endcase
    end

    // Result seen by the output register
    assign o_result.position = n_position;
    assign o_result.changed  = n_changed;

    // State registers; a start position write reloads the position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_prev_a    <= 1'b1;
            r_last_edge <= '0;
            r_reported  <= '0;
            r_changed   <= 1'b0;
        end else begin
            if (i_accept) begin
                r_position  <= n_position;
                r_prev_a    <= n_prev_a;
                r_last_edge <= n_last_edge;
                r_reported  <= n_reported;
                r_changed   <= n_changed;
            end
            if (i_start_we) begin
                r_position <= i_start_pos;
            end
        end
    end

    // After a sample the reported position tracks the live one
    `REPT_ASSERT_NEXT(a_sample_reports, i_clk, i_rst_n,
        i_accept && (i_item.cmd == CMD_SAMPLE) && !i_start_we,
        r_reported == r_position)
    // A set request leaves the changed flag alone
    `REPT_ASSERT_NEXT(a_set_keeps_flag, i_clk, i_rst_n,
        i_accept && (i_item.cmd == CMD_SET_POS),
        r_changed == $past(r_changed))
    // Accepted edges record their timestamp
    `REPT_ASSERT_NEXT(a_edge_time, i_clk, i_rst_n,
        i_accept && (i_item.cmd == CMD_SAMPLE) && edge_ok,
        r_last_edge == $past(i_item.now_ms) && !r_prev_a)

endmodule
